>>> design/apbq_pkg.sv
// Package for the all-pass biquad cascade: operation codes, controller states,
// command and status structures, configuration indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package apbq_pkg;

	typedef enum logic [1:0] {
		OP_PROC   = 2'd0,
		OP_LOAD   = 2'd1,
		OP_COMMIT = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_MUL,
		ST_ADD,
		ST_FIN
	} state_t;

	localparam logic CFG_ACTIVE = 1'b0;
	localparam logic CFG_TAP    = 1'b1;

	localparam logic [7:0] ACTIVE_RESET = 8'd128;
	localparam logic [7:0] TAP_RESET    = 8'd127;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_step;
		logic load_coef;
		logic commit;
		logic start;
		logic mod_step;
		logic mul;
		logic add;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_done;
		logic mod_done;
		logic last_sec;
		logic out_free;
	} sts_t;

endpackage

>>> design/allpass_biquad_cascade.sv
// Top level of the all-pass biquad cascade: configuration registers and the
// controller and datapath. Depends on apbq_pkg, apbq_ctrl and apbq_datapath.
`timescale 1ns / 1ps

// A cascade of second-order all-pass sections processed one section at a time
// by a single shared multiply and round unit. A sample item runs through the
// section loop, where each section's output feeds the next through a multiply
// stage and a round-saturate stage; no new item is accepted until it is done.
// Shrinking the section count without a reset makes the ring start be brought
// back by repeated subtraction of the ring length. Coefficient loads and
// commits are taken in the idle state. After reset a clearing pass over all
// 3*MAX_SECTIONS ring entries zeroes the histories and both coefficient
// banks; no item is accepted during it.

module allpass_biquad_cascade import apbq_pkg::*; #(
	parameter int MAX_SECTIONS = 128,
	parameter int SAMPLE_BITS  = 24,
	parameter int COEF_BITS    = 18
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [7:0]                    cfg_data,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [1:0]                    op,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic [6:0]                    section_index,
	input  logic signed [COEF_BITS-1:0]   coef_b,
	input  logic signed [COEF_BITS-1:0]   coef_c,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic                          saturated
);

	logic [7:0] active_q, tap_q;
	cmd_t       cmd;
	sts_t       sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
			tap_q    <= TAP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ACTIVE: active_q <= cfg_data;
				CFG_TAP:    tap_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	apbq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.op        (op),
		.sts       (sts),
		.cmd       (cmd)
	);

	apbq_datapath #(
		.MAX_SECTIONS (MAX_SECTIONS),
		.SAMPLE_BITS  (SAMPLE_BITS),
		.COEF_BITS    (COEF_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.active_sections (active_q),
		.tap_select      (tap_q),
		.sample_in       (sample_in),
		.section_index   (section_index),
		.coef_b          (coef_b),
		.coef_c          (coef_c),
		.sample_out      (sample_out),
		.saturated       (saturated),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall)
	);

endmodule

>>> design/apbq_ram.sv
// Generic memory: one write port and two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module apbq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re_a,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	output logic [WIDTH-1:0]                      rdata_a,
	input  logic                                  re_b,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [WIDTH-1:0]                      rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re_a) begin
			rdata_a <= mem_q[raddr_a];
		end
		if (re_b) begin
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

>>> design/apbq_ctrl.sv
// Controller state machine of the all-pass biquad cascade.
// Depends on apbq_pkg; drives the datapath through cmd_t and reads sts_t.
`timescale 1ns / 1ps

module apbq_ctrl import apbq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [1:0] op,
	input  sts_t       sts,
	output cmd_t       cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					case (op)
						OP_PROC: begin
							cmd.start = 1'b1;
							state_d   = ST_MOD;
						end
						OP_LOAD:   cmd.load_coef = 1'b1;
						OP_COMMIT: cmd.commit = 1'b1;
						default:   ;
					endcase
				end
			end
			ST_MOD: begin
				// Reduce the ring start into range, then fetch section zero.
				cmd.mod_step = 1'b1;
				if (sts.mod_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.add = 1'b1;
				state_d = sts.last_sec ? ST_FIN : ST_MUL;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

endmodule

>>> design/apbq_datapath.sv
// Datapath of the all-pass biquad cascade: history ring and coefficient memories,
// ring addressing, multiply and round-saturate stages, output register.
// Depends on apbq_pkg and apbq_ram.
`timescale 1ns / 1ps

module apbq_datapath import apbq_pkg::*; #(
	parameter int MAX_SECTIONS = 128,
	parameter int SAMPLE_BITS  = 24,
	parameter int COEF_BITS    = 18
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cmd_t                          cmd,
	output sts_t                          sts,
	input  logic [7:0]                    active_sections,
	input  logic [7:0]                    tap_select,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic [6:0]                    section_index,
	input  logic signed [COEF_BITS-1:0]   coef_b,
	input  logic signed [COEF_BITS-1:0]   coef_c,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic                          saturated,
	output logic                          rsp_valid,
	input  logic                          rsp_stall
);

	localparam int SB         = SAMPLE_BITS;
	localparam int RING_SLOTS = 3 * MAX_SECTIONS;
	localparam int CDEPTH     = 2 * MAX_SECTIONS;
	localparam int NP_W       = $clog2(RING_SLOTS + 1);
	localparam int RA_W       = $clog2(RING_SLOTS);
	localparam int CA_W       = $clog2(CDEPTH);
	localparam int CNT_W      = $clog2(MAX_SECTIONS + 1);
	localparam int FRAC       = COEF_BITS - 2;
	localparam int PW         = SB + 1 + COEF_BITS;
	localparam int SW         = PW + 2;
	localparam int EW         = 2 * SB;
	localparam int CW         = 2 * COEF_BITS;
	localparam logic signed [SW-1:0] HALF = SW'(64'sd1 <<< (FRAC - 1));
	localparam logic signed [SW-1:0] SMAX = SW'((64'sd1 <<< (SB - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] SMIN = SW'(-(64'sd1 <<< (SB - 1)));

	function automatic logic [NP_W-1:0] wrap_add(input logic [NP_W-1:0] p,
			input logic [1:0] k, input logic [NP_W-1:0] n);
		logic [NP_W:0] s;
		s = {1'b0, p} + (NP_W + 1)'(k);
		if (s >= {1'b0, n}) begin
			s = s - {1'b0, n};
		end
		return s[NP_W-1:0];
	endfunction

	logic [CNT_W-1:0]          count_q, count_c, f_q, ridx_c;
	logic [NP_W-1:0]           np_q, ring_start_q, p2_q, s0_q, clr_q, rd_p2_c, p2_next_c;
	logic signed [SB-1:0]      un_q, result_q, u2_q, ysat_c;
	logic                      clip_q, live_q, pending_q, clip_c;
	logic signed [PW-1:0]      prod0_q, prod1_q;
	logic signed [SW-1:0]      sum_c, yv_c;
	logic signed [SB:0]        d0_c, d1_c;
	logic signed [SB-1:0]      u1_c, u2_c, y1_c, y2_c;
	logic signed [COEF_BITS-1:0] cb_c, cc_c;
	logic                      ring_re, ring_we, coef_we, load_ok;
	logic [RA_W-1:0]           ring_waddr;
	logic [EW-1:0]             ring_wdata, ring_rd_a, ring_rd_b;
	logic [CA_W-1:0]           coef_waddr, coef_raddr;
	logic [CW-1:0]             coef_wdata, coef_rd;
	logic signed [SB-1:0]      sample_out_q;
	logic                      sat_q, out_valid_q;

	// Effective section count: zero acts as one, large values clip to the maximum.
	always_comb begin
		if (active_sections == 8'd0) begin
			count_c = CNT_W'(1);
		end else if (32'(active_sections) > MAX_SECTIONS) begin
			count_c = CNT_W'(MAX_SECTIONS);
		end else begin
			count_c = CNT_W'(active_sections);
		end
	end

	assign sts.clear_done = (clr_q == NP_W'(RING_SLOTS - 1));
	assign sts.mod_done   = (ring_start_q < np_q);
	assign sts.last_sec   = (f_q == count_q - CNT_W'(1));
	assign sts.out_free   = !out_valid_q || !rsp_stall;

	// Read address selection: section zero after the ring start is reduced,
	// otherwise the next section while the current one multiplies.
	assign p2_next_c = wrap_add(p2_q, 2'd3, np_q);
	always_comb begin
		ring_re = 1'b0;
		rd_p2_c = ring_start_q;
		ridx_c  = '0;
		if (cmd.mod_step && sts.mod_done) begin
			ring_re = 1'b1;
		end else if (cmd.mul && !sts.last_sec) begin
			ring_re = 1'b1;
			rd_p2_c = p2_next_c;
			ridx_c  = f_q + CNT_W'(1);
		end
	end

	assign coef_raddr = live_q ? CA_W'(MAX_SECTIONS) + CA_W'(ridx_c) : CA_W'(ridx_c);

	assign load_ok    = cmd.load_coef && (32'(section_index) < MAX_SECTIONS);
	assign ring_we    = cmd.clear_step || cmd.add;
	assign ring_waddr = cmd.clear_step ? clr_q[RA_W-1:0] : s0_q[RA_W-1:0];
	assign ring_wdata = cmd.clear_step ? '0 : {un_q, ysat_c};
	assign coef_we    = (cmd.clear_step && (clr_q < NP_W'(CDEPTH))) || load_ok;
	always_comb begin
		if (cmd.clear_step) begin
			coef_waddr = clr_q[CA_W-1:0];
			coef_wdata = '0;
		end else begin
			coef_waddr = live_q ? CA_W'(section_index) :
				CA_W'(MAX_SECTIONS) + CA_W'(section_index);
			coef_wdata = {coef_b, coef_c};
		end
	end

	apbq_ram #(.WIDTH(EW), .DEPTH(RING_SLOTS)) u_ring (
		.clk     (clk),
		.we      (ring_we),
		.waddr   (ring_waddr),
		.wdata   (ring_wdata),
		.re_a    (ring_re),
		.raddr_a (rd_p2_c[RA_W-1:0]),
		.rdata_a (ring_rd_a),
		.re_b    (ring_re),
		.raddr_b (wrap_add(rd_p2_c, 2'd1, np_q)),
		.rdata_b (ring_rd_b)
	);

	apbq_ram #(.WIDTH(CW), .DEPTH(CDEPTH)) u_coef (
		.clk     (clk),
		.we      (coef_we),
		.waddr   (coef_waddr),
		.wdata   (coef_wdata),
		.re_a    (ring_re),
		.raddr_a (coef_raddr),
		.rdata_a (coef_rd),
		.re_b    (1'b0),
		.raddr_b (coef_raddr),
		.rdata_b ()
	);

	// Each ring entry holds a section input above the matching section output.
	assign u2_c = ring_rd_a[EW-1:SB];
	assign y2_c = ring_rd_a[SB-1:0];
	assign u1_c = ring_rd_b[EW-1:SB];
	assign y1_c = ring_rd_b[SB-1:0];
	assign cb_c = coef_rd[CW-1:COEF_BITS];
	assign cc_c = coef_rd[COEF_BITS-1:0];
	assign d0_c = (SB + 1)'(un_q) - (SB + 1)'(y2_c);
	assign d1_c = (SB + 1)'(u1_c) - (SB + 1)'(y1_c);

	// Exact sum rounded half up to sample precision, then clipped.
	always_comb begin
		sum_c  = SW'(prod0_q) + SW'(prod1_q) + (SW'(u2_q) <<< FRAC) + HALF;
		yv_c   = sum_c >>> FRAC;
		clip_c = 1'b0;
		if (yv_c > SMAX) begin
			ysat_c = SMAX[SB-1:0];
			clip_c = 1'b1;
		end else if (yv_c < SMIN) begin
			ysat_c = SMIN[SB-1:0];
			clip_c = 1'b1;
		end else begin
			ysat_c = yv_c[SB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod0_q <= PW'(d0_c) * PW'(cc_c);
			prod1_q <= PW'(d1_c) * PW'(cb_c);
			u2_q    <= u2_c;
			s0_q    <= wrap_add(p2_q, 2'd2, np_q);
		end
		if (cmd.start) begin
			un_q    <= sample_in;
			count_q <= count_c;
			np_q    <= NP_W'(count_c) + (NP_W'(count_c) << 1);
		end else if (cmd.add) begin
			un_q <= ysat_c;
		end
		if (cmd.finish) begin
			sample_out_q <= result_q;
			sat_q        <= clip_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			ring_start_q <= '0;
			p2_q         <= '0;
			f_q          <= '0;
			result_q     <= '0;
			clip_q       <= 1'b0;
			live_q       <= 1'b0;
			pending_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.clear_step) begin
				clr_q <= clr_q + NP_W'(1);
			end
			if (cmd.commit) begin
				pending_q <= 1'b1;
			end
			if (cmd.start) begin
				f_q      <= '0;
				result_q <= '0;
				clip_q   <= 1'b0;
			end
			if (cmd.mod_step) begin
				if (sts.mod_done) begin
					p2_q <= ring_start_q;
				end else begin
					ring_start_q <= ring_start_q - np_q;
				end
			end
			if (cmd.mul) begin
				p2_q <= p2_next_c;
			end
			if (cmd.add) begin
				f_q    <= f_q + CNT_W'(1);
				clip_q <= clip_q | clip_c;
				if (32'(f_q) == 32'(tap_select)) begin
					result_q <= ysat_c;
				end
				if (sts.last_sec) begin
					ring_start_q <= wrap_add(ring_start_q, 2'd1, np_q);
					if (pending_q) begin
						live_q    <= !live_q;
						pending_q <= 1'b0;
					end
				end
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sample_out = sample_out_q;
	assign saturated  = sat_q;
	assign rsp_valid  = out_valid_q;

`ifndef NO_ASSERTIONS
	a_ring_start_range: assert property (@(posedge clk) disable iff (!arst_n)
		ring_start_q < NP_W'(RING_SLOTS))
		else $error("ring start beyond ring length");
	a_ring_advance: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add && sts.last_sec |=> ring_start_q < np_q)
		else $error("ring start left out of range after a sample");
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul |-> p2_q < np_q)
		else $error("section pointer outside the ring");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !out_valid_q || !rsp_stall)
		else $error("result register overwritten while held");
`endif

endmodule
